>>> rtl/core/svbm_pkg.sv
package svbm_pkg;

  localparam int unsigned AddrW                = 32;
  localparam int unsigned SegShift             = 9;
  localparam int unsigned BlocksPerSegment     = 2 ** SegShift;
  localparam int unsigned WordShift            = 6;
  localparam int unsigned WordW                = 2 ** WordShift;
  localparam int unsigned WordIdxW             = SegShift - WordShift;
  localparam int unsigned OffW                 = SegShift;
  localparam int unsigned PieceW               = SegShift + 1;
  localparam int unsigned SegW                 = AddrW - SegShift;
  localparam int unsigned MaxSegments          = 1024;
  localparam int unsigned SegIdxW              = $clog2(MaxSegments);
  localparam int unsigned BitmapWords          = MaxSegments * (BlocksPerSegment / WordW);
  localparam int unsigned BmAddrW              = $clog2(BitmapWords);
  localparam int unsigned MaxRun               = 4096;
  localparam int unsigned RunW                 = 13;
  localparam int unsigned CountMax             = 511;
  localparam int unsigned CntW                 = 9;
  localparam int unsigned LimitW               = 11;
  localparam int unsigned EntriesPerTableBlock = 55;
  localparam int unsigned IdxW                 = 6;
  localparam int unsigned DivShift             = 24;
  localparam int unsigned Recip                = (2 ** DivShift) / EntriesPerTableBlock;
  localparam int unsigned RecipW               = $clog2(Recip + 1);
  localparam int unsigned QuoW                 =
      $clog2((2 ** SegW - 1) / EntriesPerTableBlock + 1);
  localparam int unsigned CfgAddrW             = 4;
  localparam int unsigned CfgDataW             = 32;

  typedef enum logic [1:0] {
    RegFirstDataBlock  = 2'd0,
    RegTableStartBlock = 2'd1,
    RegSegmentsInUse   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusAlready = 2'd1,
    StatusOutside = 2'd2
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0]  first_data_block;
    logic [AddrW-1:0]  table_start_block;
    logic [LimitW-1:0] segments_in_use;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] start_block;
    logic [RunW-1:0]  block_count;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [9:0]       segment_id;
    logic [AddrW-1:0] entry_block_addr;
    logic [IdxW-1:0]  entry_index;
    logic [CntW-1:0]  valid_count;
    logic             last;
  } res_t;

endpackage

>>> rtl/core/svbm_stream_if.sv
interface svbm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/svbm_apb_regs.sv
module svbm_apb_regs import svbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [CfgDataW-1:0] pwdata_i,
  output logic [CfgDataW-1:0] prdata_o,
  output logic                pready_o,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx      = reg_idx_e'(paddr_i[CfgAddrW-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegFirstDataBlock:  cfg_d.first_data_block  = pwdata_i;
        RegTableStartBlock: cfg_d.table_start_block = pwdata_i;
        RegSegmentsInUse:   cfg_d.segments_in_use   = pwdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegFirstDataBlock:  prdata_o = cfg_q.first_data_block;
      RegTableStartBlock: prdata_o = cfg_q.table_start_block;
      RegSegmentsInUse:   prdata_o = CfgDataW'(cfg_q.segments_in_use);
      default:            prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_data_block  <= '0;
      cfg_q.table_start_block <= '0;
      cfg_q.segments_in_use   <= LimitW'(MaxSegments);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/core/svbm_sdp_ram.sv
module svbm_sdp_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/svbm_seg_div.sv
module svbm_seg_div import svbm_pkg::*; (
  input  logic            clk_i,
  input  logic [SegW-1:0] seg_i,
  output logic [QuoW-1:0] quo_o,
  output logic [IdxW-1:0] rem_o
);

  localparam int unsigned ProdW = SegW + RecipW;

  logic [ProdW-1:0] prod_q, prod_d;
  logic [SegW-1:0]  seg_q;
  logic [QuoW-1:0]  quo_est;
  logic [SegW-1:0]  back;
  logic [SegW-1:0]  diff;
  logic [IdxW:0]    rem_est;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic [IdxW-1:0]  rem_q, rem_d;

  assign prod_d  = ProdW'(seg_i) * ProdW'(Recip);
  assign quo_est = prod_q[DivShift +: QuoW];
  assign back    = SegW'(quo_est) * SegW'(EntriesPerTableBlock);
  assign diff    = seg_q - back;
  assign rem_est = diff[IdxW:0];

  // estimate is low by at most one
  always_comb begin
    if (rem_est >= (IdxW + 1)'(EntriesPerTableBlock)) begin
      quo_d = quo_est + QuoW'(1);
      rem_d = IdxW'(rem_est - (IdxW + 1)'(EntriesPerTableBlock));
    end else begin
      quo_d = quo_est;
      rem_d = rem_est[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    seg_q  <= seg_i;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

>>> rtl/core/segment_valid_block_map_core.sv
// Segment validity map. After reset the block runs a clearing pass over the bitmap memory
// (and the count memory alongside it) before it accepts the first request; configuration
// writes are taken throughout. A request is accepted in StIdle; an empty request (zero
// blocks or the all-ones address) ends there. Each segment piece then passes through
// StSeg, StDiv, StCnt, StWord and StOut. StWord steps through the 64-bit bitmap words the
// piece covers (1 to 8), since the bitmap memory port reads one word and writes back one
// word per cycle; a piece outside the volume skips StWord. A run of 4096 blocks spans at
// most 9 pieces. Results leave through an output register, so a stalled consumer holds the
// block only once the next result is ready.
module segment_valid_block_map_core import svbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  svbm_stream_if.sink         req_i,
  svbm_stream_if.source       res_o
);

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StSeg   = 7'b0000100,
    StDiv   = 7'b0001000,
    StCnt   = 7'b0010000,
    StWord  = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg;

  logic [BmAddrW-1:0]  clr_q, clr_d;
  logic                kind_q, kind_d;
  logic [AddrW-1:0]    cur_q, cur_d;
  logic [RunW-1:0]     left_q, left_d;
  logic [SegW-1:0]     seg_q, seg_d;
  logic [OffW-1:0]     off_q, off_d;
  logic [OffW-1:0]     end_q, end_d;
  logic [PieceW-1:0]   piece_q, piece_d;
  logic [WordIdxW-1:0] wlo_q, wlo_d;
  logic [WordIdxW-1:0] whi_q, whi_d;
  logic [WordIdxW-1:0] widx_q, widx_d;
  logic                inrange_q, inrange_d;
  logic [CntW-1:0]     cnt_new_q, cnt_new_d;
  logic                flag_q, flag_d;
  logic                issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [BmAddrW-1:0]  pend_addr_q, pend_addr_d;
  logic [WordW-1:0]    pend_mask_q, pend_mask_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic                bm_we, bm_re;
  logic [BmAddrW-1:0]  bm_waddr, bm_raddr;
  logic [WordW-1:0]    bm_wdata, bm_rdata;
  logic                cnt_we, cnt_re;
  logic [SegIdxW-1:0]  cnt_waddr;
  logic [CntW-1:0]     cnt_wdata, cnt_rdata;

  logic [QuoW-1:0]     quo;
  logic [IdxW-1:0]     rem;

  logic [AddrW-1:0]    rel;
  logic [PieceW-1:0]   room;
  logic [PieceW-1:0]   piece_c;
  logic [PieceW-1:0]   end_c;
  logic [LimitW-1:0]   limit;
  logic [RunW-1:0]     run_clamped;
  logic [CntW+1:0]     cnt_sum;
  logic [CntW-1:0]     cnt_next;
  logic [WordW-1:0]    word_mask;
  logic [BmAddrW-1:0]  rd_addr;
  logic                hit;
  logic [WordW-1:0]    bm_merge;
  logic                out_load;
  logic                req_ready;

  svbm_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  svbm_sdp_ram #(
    .Width (WordW),
    .Depth (BitmapWords)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  svbm_sdp_ram #(
    .Width (CntW),
    .Depth (MaxSegments)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (seg_q[SegIdxW-1:0]),
    .rdata_o (cnt_rdata)
  );

  svbm_seg_div u_div (
    .clk_i (clk_i),
    .seg_i (seg_q),
    .quo_o (quo),
    .rem_o (rem)
  );

  assign rel     = cur_q - cfg.first_data_block;
  assign room    = PieceW'(BlocksPerSegment) - PieceW'(rel[OffW-1:0]);
  assign piece_c = (RunW'(room) > left_q) ? left_q[PieceW-1:0] : room;
  assign end_c   = PieceW'(rel[OffW-1:0]) + piece_c - PieceW'(1);

  assign limit = (cfg.segments_in_use > LimitW'(MaxSegments)) ?
                 LimitW'(MaxSegments) : cfg.segments_in_use;

  assign run_clamped = (req_i.payload.block_count > RunW'(MaxRun)) ?
                       RunW'(MaxRun) : req_i.payload.block_count;

  assign cnt_sum = (CntW + 2)'(cnt_rdata) + (CntW + 2)'(piece_q);

  // saturate at both ends
  always_comb begin
    if (kind_q) begin
      cnt_next = (cnt_sum > (CntW + 2)'(CountMax)) ? CntW'(CountMax) : cnt_sum[CntW-1:0];
    end else if (PieceW'(cnt_rdata) >= piece_q) begin
      cnt_next = CntW'(PieceW'(cnt_rdata) - piece_q);
    end else begin
      cnt_next = '0;
    end
  end

  always_comb begin
    logic [WordShift-1:0] lo;
    logic [WordShift-1:0] hi;
    lo = (widx_q == wlo_q) ? off_q[WordShift-1:0] : '0;
    hi = (widx_q == whi_q) ? end_q[WordShift-1:0] : '1;
    word_mask = ({WordW{1'b1}} << lo) & ({WordW{1'b1}} >> (~hi));
  end

  assign rd_addr  = {seg_q[SegIdxW-1:0], widx_q};
  assign hit      = kind_q ? |(bm_rdata & pend_mask_q) : |(~bm_rdata & pend_mask_q);
  assign bm_merge = kind_q ? (bm_rdata | pend_mask_q) : (bm_rdata & ~pend_mask_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    cur_d       = cur_q;
    left_d      = left_q;
    seg_d       = seg_q;
    off_d       = off_q;
    end_d       = end_q;
    piece_d     = piece_q;
    wlo_d       = wlo_q;
    whi_d       = whi_q;
    widx_d      = widx_q;
    inrange_d   = inrange_q;
    cnt_new_d   = cnt_new_q;
    flag_d      = flag_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_mask_d = pend_mask_q;
    req_ready   = 1'b0;
    bm_we       = 1'b0;
    bm_waddr    = pend_addr_q;
    bm_wdata    = bm_merge;
    bm_re       = 1'b0;
    bm_raddr    = rd_addr;
    cnt_we      = 1'b0;
    cnt_waddr   = seg_q[SegIdxW-1:0];
    cnt_wdata   = cnt_next;
    cnt_re      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      StClear: begin
        bm_we     = 1'b1;
        bm_waddr  = clr_q;
        bm_wdata  = '0;
        cnt_we    = (clr_q < BmAddrW'(MaxSegments));
        cnt_waddr = clr_q[SegIdxW-1:0];
        cnt_wdata = '0;
        clr_d     = clr_q + BmAddrW'(1);
        if (clr_q == BmAddrW'(BitmapWords - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          kind_d = req_i.payload.kind;
          cur_d  = req_i.payload.start_block;
          left_d = run_clamped;
          if (req_i.payload.start_block != '1 && req_i.payload.block_count != '0) begin
            state_d = StSeg;
          end
        end
      end
      StSeg: begin
        seg_d   = rel[AddrW-1:SegShift];
        off_d   = rel[OffW-1:0];
        piece_d = piece_c;
        end_d   = end_c[OffW-1:0];
        wlo_d   = rel[OffW-1:WordShift];
        whi_d   = end_c[OffW-1:WordShift];
        flag_d  = 1'b0;
        state_d = StDiv;
      end
      StDiv: begin
        cnt_re    = 1'b1;
        inrange_d = (seg_q < SegW'(limit));
        state_d   = StCnt;
      end
      StCnt: begin
        if (inrange_q) begin
          cnt_we    = 1'b1;
          cnt_new_d = cnt_next;
          widx_d    = wlo_q;
          issue_d   = 1'b1;
          pend_d    = 1'b0;
          state_d   = StWord;
        end else begin
          cnt_new_d = '0;
          state_d   = StOut;
        end
      end
      StWord: begin
        // read the next word while the previous one is written back
        if (pend_q) begin
          bm_we  = 1'b1;
          flag_d = flag_q | hit;
        end
        if (issue_q) begin
          bm_re       = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = rd_addr;
          pend_mask_d = word_mask;
          widx_d      = widx_q + WordIdxW'(1);
          issue_d     = (widx_q != whi_q);
        end else begin
          pend_d  = 1'b0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          cur_d    = cur_q + AddrW'(piece_q);
          left_d   = left_q - RunW'(piece_q);
          state_d  = (left_q == RunW'(piece_q)) ? StIdle : StSeg;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d            = 1'b1;
      out_d.status           = !inrange_q ? StatusOutside :
                               (flag_q ? StatusAlready : StatusOk);
      out_d.segment_id       = seg_q[9:0];
      out_d.entry_block_addr = cfg.table_start_block + AddrW'(quo);
      out_d.entry_index      = rem;
      out_d.valid_count      = cnt_new_q;
      out_d.last             = (left_q == RunW'(piece_q));
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    cur_q       <= cur_d;
    left_q      <= left_d;
    seg_q       <= seg_d;
    off_q       <= off_d;
    end_q       <= end_d;
    piece_q     <= piece_d;
    wlo_q       <= wlo_d;
    whi_q       <= whi_d;
    widx_q      <= widx_d;
    inrange_q   <= inrange_d;
    cnt_new_q   <= cnt_new_d;
    flag_q      <= flag_d;
    pend_addr_q <= pend_addr_d;
    pend_mask_q <= pend_mask_d;
    out_q       <= out_d;
  end

  assign req_i.ready   = req_ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !out_valid_q)
    else $error("result presented during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWord) |-> inrange_q)
    else $error("bitmap update for a segment outside the volume");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWord && pend_q && issue_q) |-> (pend_addr_q != rd_addr))
    else $error("bitmap read and write-back hit the same word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |=> (state_q == StIdle))
    else $error("last result without return to idle");

endmodule

>>> tb/sv/tb_segment_valid_block_map_checker.sv
`timescale 1ns / 1ps

module tb_segment_valid_block_map_checker import svbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic                pready,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  req_t                req_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  res_t                res_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);

  bit [WordW-1:0]    bitmap_mirror [BitmapWords];
  bit [CntW-1:0]     count_mirror [MaxSegments];
  logic [AddrW-1:0]  first_blk;
  logic [AddrW-1:0]  table_blk;
  logic [LimitW-1:0] seg_limit;
  res_t              segment_updates_q [$];
  int                err_cnt;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic apply_run(input req_t rq);
    logic [31:0] cur;
    logic [31:0] rel;
    logic [31:0] seg;
    logic [31:0] off;
    logic [31:0] piece;
    logic [31:0] left;
    logic [31:0] lim;
    logic [31:0] cnt;
    int unsigned bitno;
    status_e     st;
    res_t        upd;
    if (rq.start_block == '1 || rq.block_count == 0) return;
    left = rq.block_count;
    if (left > MaxRun) left = MaxRun;
    lim = (seg_limit > MaxSegments) ? MaxSegments : seg_limit;
    cur = rq.start_block;
    while (left != 0) begin
      rel   = cur - first_blk;
      seg   = rel / BlocksPerSegment;
      off   = rel % BlocksPerSegment;
      piece = BlocksPerSegment - off;
      if (piece > left) piece = left;
      st  = StatusOk;
      cnt = 0;
      if (seg >= lim) begin
        st = StatusOutside;
      end else begin
        cnt = count_mirror[seg];
        for (int i = 0; i < piece; i++) begin
          bitno = seg * BlocksPerSegment + off + i;
          if (rq.kind) begin
            if (bitmap_mirror[bitno / WordW][bitno % WordW]) st = StatusAlready;
            bitmap_mirror[bitno / WordW][bitno % WordW] = 1'b1;
            if (cnt < CountMax) cnt++;
          end else begin
            if (!bitmap_mirror[bitno / WordW][bitno % WordW]) st = StatusAlready;
            bitmap_mirror[bitno / WordW][bitno % WordW] = 1'b0;
            if (cnt > 0) cnt--;
          end
        end
        count_mirror[seg] = cnt[CntW-1:0];
      end
      upd.status           = st;
      upd.segment_id       = seg[9:0];
      upd.entry_block_addr = table_blk + seg / EntriesPerTableBlock;
      upd.entry_index      = IdxW'(seg % EntriesPerTableBlock);
      upd.valid_count      = cnt[CntW-1:0];
      upd.last             = (left == piece);
      segment_updates_q.push_back(upd);
      cur  = cur + piece;
      left = left - piece;
    end
  endtask

  task automatic compare_update(input res_t got);
    res_t want;
    if (segment_updates_q.size() == 0) begin
      flag_mismatch("unexpected transfer, segment_id", got.segment_id, 0);
      return;
    end
    want = segment_updates_q.pop_front();
    if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
    if (got.segment_id !== want.segment_id) begin
      flag_mismatch("segment_id", got.segment_id, want.segment_id);
    end
    if (got.entry_block_addr !== want.entry_block_addr) begin
      flag_mismatch("entry_block_addr", got.entry_block_addr, want.entry_block_addr);
    end
    if (got.entry_index !== want.entry_index) begin
      flag_mismatch("entry_index", got.entry_index, want.entry_index);
    end
    if (got.valid_count !== want.valid_count) begin
      flag_mismatch("valid_count", got.valid_count, want.valid_count);
    end
    if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bitmap_mirror[i]) bitmap_mirror[i] = '0;
      foreach (count_mirror[i]) count_mirror[i] = '0;
      first_blk = '0;
      table_blk = '0;
      seg_limit = LimitW'(MaxSegments);
      segment_updates_q.delete();
      err_cnt = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[CfgAddrW-1:2]))
          RegFirstDataBlock:  first_blk = pwdata[AddrW-1:0];
          RegTableStartBlock: table_blk = pwdata[AddrW-1:0];
          RegSegmentsInUse:   seg_limit = pwdata[LimitW-1:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) compare_update(res_i);
      if (req_valid_i && req_ready_i) apply_run(req_i);
      mismatches_o  <= err_cnt;
      outstanding_o <= segment_updates_q.size();
    end
  end

endmodule

>>> tb/sv/tb_segment_valid_block_map_core.sv
`timescale 1ns / 1ps

module tb_segment_valid_block_map_core;
  import svbm_pkg::*;

  localparam int unsigned SettleCycles = 200;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic [1:0]          stall_mode;
  logic [5:0]          stall_tick;
  int                  mismatches;
  int                  outstanding;

  svbm_stream_if #(.payload_t(req_t)) req_if ();
  svbm_stream_if #(.payload_t(res_t)) res_if ();

  segment_valid_block_map_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .res_o   (res_if)
  );

  tb_segment_valid_block_map_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_i         (req_if.payload),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_i         (res_if.payload),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_mode   <= '0;
      stall_tick   <= '0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '0) stall_mode <= 2'($urandom_range(0, 2));
      case (stall_mode)
        2'd0:    res_if.ready <= 1'b1;
        2'd1:    res_if.ready <= 1'($urandom_range(0, 1));
        default: res_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_volume(input logic [31:0] first_blk, input logic [31:0] table_blk,
                            input int unsigned segs);
    cfg_write(RegFirstDataBlock, first_blk);
    cfg_write(RegTableStartBlock, table_blk);
    cfg_write(RegSegmentsInUse, segs);
  endtask

  function automatic req_t mark_run(input logic kind, input logic [31:0] start,
                                    input int unsigned count);
    req_t rq;
    rq.kind        = kind;
    rq.start_block = start;
    rq.block_count = RunW'(count);
    return rq;
  endfunction

  function automatic req_t random_run(input logic [31:0] base, input int unsigned segs);
    req_t        rq;
    int unsigned pick;
    int unsigned seg;
    int unsigned len_pick;
    pick     = $urandom_range(0, 99);
    len_pick = $urandom_range(0, 99);
    seg      = (pick < 55) ? $urandom_range(0, 7) : $urandom_range(0, segs + 2);
    rq.kind        = 1'($urandom_range(0, 1));
    rq.start_block = base + seg * BlocksPerSegment + $urandom_range(0, BlocksPerSegment - 1);
    if (len_pick < 65)      rq.block_count = RunW'($urandom_range(1, 64));
    else if (len_pick < 88) rq.block_count = RunW'($urandom_range(1, 600));
    else if (len_pick < 96) rq.block_count = RunW'($urandom_range(513, MaxRun));
    else                    rq.block_count = RunW'($urandom_range(MaxRun + 1, 8191));
    if (pick >= 94)      rq.start_block = $urandom;
    else if (pick >= 92) rq.block_count = '0;
    else if (pick >= 91) rq.start_block = '1;
    return rq;
  endfunction

  task automatic run_phase(input req_t items [$]);
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < items.size()) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && idx < items.size()) begin
        req_if.valid   <= 1'b1;
        req_if.payload <= items[idx];
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0 || idx == items.size()) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    req_t        plan [$];
    logic [31:0] first_blk;
    logic [31:0] table_blk;
    int unsigned segs;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    set_volume(32'd0, 32'd0, MaxSegments);
    plan = '{};
    plan.push_back(mark_run(1'b1, 32'd0, 512));
    plan.push_back(mark_run(1'b1, 32'd0, 512));
    plan.push_back(mark_run(1'b0, 32'd0, 512));
    plan.push_back(mark_run(1'b0, 32'd0, 1));
    plan.push_back(mark_run(1'b1, 32'd100, 0));
    plan.push_back(mark_run(1'b1, 32'hFFFF_FFFF, 10));
    plan.push_back(mark_run(1'b1, 32'd300, MaxRun));
    plan.push_back(mark_run(1'b0, 32'd300, 8191));
    plan.push_back(mark_run(1'b1, 32'd1023 * 512 + 500, 100));
    plan.push_back(mark_run(1'b1, 32'hFFFF_FFF0, 32));
    plan.push_back(mark_run(1'b1, 32'hFFFF_FFFE, 1));
    plan.push_back(mark_run(1'b0, 32'd1, 1));
    run_phase(plan);

    set_volume(32'd1000, 32'hFFFF_FFF0, 1);
    plan = '{};
    plan.push_back(mark_run(1'b1, 32'd999, 2));
    plan.push_back(mark_run(1'b1, 32'd1512, 1));
    plan.push_back(mark_run(1'b1, 32'd1000, MaxRun));
    plan.push_back(mark_run(1'b0, 32'd0, 1));
    plan.push_back(mark_run(1'b0, 32'd1000, 600));
    run_phase(plan);

    set_volume(32'hFFFF_FFFF, 32'hFFFF_FFFF, MaxSegments);
    plan = '{};
    plan.push_back(mark_run(1'b1, 32'd0, 512));
    plan.push_back(mark_run(1'b0, 32'hFFFF_FFFE, 3));
    plan.push_back(mark_run(1'b1, 32'd1023 * 512 - 1, 600));
    run_phase(plan);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          first_blk = '0;
          table_blk = $urandom;
          segs      = MaxSegments;
        end
        1: begin
          first_blk = $urandom;
          table_blk = $urandom;
          segs      = $urandom_range(1, MaxSegments);
        end
        2: begin
          first_blk = $urandom_range(0, 4095);
          table_blk = '0;
          segs      = $urandom_range(1, 16);
        end
        default: begin
          first_blk = 32'hFFFF_FFFF - $urandom_range(0, 65535);
          table_blk = 32'hFFFF_FFFF - $urandom_range(0, 20);
          segs      = MaxSegments;
        end
      endcase
      set_volume(first_blk, table_blk, segs);
      plan = '{};
      repeat (65) plan.push_back(random_run(first_blk, segs));
      run_phase(plan);
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/svbm_pkg.sv
rtl/core/svbm_stream_if.sv
rtl/core/svbm_apb_regs.sv
rtl/core/svbm_sdp_ram.sv
rtl/core/svbm_seg_div.sv
rtl/core/segment_valid_block_map_core.sv
tb/sv/tb_segment_valid_block_map_checker.sv
tb/sv/tb_segment_valid_block_map_core.sv
